// ===== design/mme_pkg.sv =====
package mme_pkg;

	// Item kinds carried on the input tuser field
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_START  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_A_ROWS    = 2'd0;
	localparam logic [1:0] REG_INNER_LEN = 2'd1;
	localparam logic [1:0] REG_B_COLS    = 2'd2;

	localparam int CFG_WIDTH   = 4;
	localparam int VALUE_WIDTH = 16;
	localparam int PROD_WIDTH  = 32;
	localparam int IDX_WIDTH   = 3;
	localparam int ACC_WIDTH   = 64;

	localparam logic [CFG_WIDTH-1:0] A_ROWS_RESET    = 4'd4;
	localparam logic [CFG_WIDTH-1:0] INNER_LEN_RESET = 4'd2;
	localparam logic [CFG_WIDTH-1:0] B_COLS_RESET    = 4'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_RUN
	} ctrl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic issue;
		logic first_k;
		logic last_k;
		logic last_elem;
	} mme_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic pipe_busy;
		logic out_full;
	} mme_stat_t;

endpackage

// ===== design/mme_ctrl.sv =====
module mme_ctrl #(
	parameter int MAX_DIM = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [1:0]                        s_kind,
	input  logic                              cfg_wr_en,
	input  logic [1:0]                        cfg_index,
	input  logic [mme_pkg::CFG_WIDTH-1:0]     cfg_data,
	output mme_pkg::mme_cmd_t                 cmd,
	input  mme_pkg::mme_stat_t                stat,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr_a,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr_b,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_a,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr_b,
	output logic [$clog2(MAX_DIM)-1:0]        row,
	output logic [$clog2(MAX_DIM)-1:0]        col
);
	import mme_pkg::*;

	localparam int CAP = MAX_DIM * MAX_DIM;
	localparam int AW  = $clog2(CAP);
	localparam int FW  = $clog2(CAP + 1);
	localparam int IW  = $clog2(MAX_DIM);
	localparam int DW  = $clog2(MAX_DIM + 1);

	logic [CFG_WIDTH-1:0] a_rows_q, inner_len_q, b_cols_q;
	logic [DW-1:0]        rows_eff, inner_eff, cols_eff;
	logic [FW-1:0]        a_fill_q, b_fill_q;
	logic [IW-1:0]        i_q, j_q, k_q;
	logic [AW-1:0]        a_base_q, ia_q, ib_q;
	ctrl_state_t          state_q, state_d;
	logic                 accept, k_end, elem_end;

	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_WIDTH-1:0] r);
		logic [DW-1:0] d;
		if (r == '0)
			d = DW'(1);
		else if (r > CFG_WIDTH'(MAX_DIM))
			d = DW'(MAX_DIM);
		else
			d = DW'(r);
		return d;
	endfunction

	assign rows_eff  = clamp_dim(a_rows_q);
	assign inner_eff = clamp_dim(inner_len_q);
	assign cols_eff  = clamp_dim(b_cols_q);

	assign accept   = s_tvalid && s_tready;
	assign k_end    = (k_q == IW'(inner_eff - DW'(1)));
	assign elem_end = (i_q == IW'(rows_eff - DW'(1))) && (j_q == IW'(cols_eff - DW'(1)));

	assign wr_addr_a = a_fill_q[AW-1:0];
	assign wr_addr_b = b_fill_q[AW-1:0];
	assign rd_addr_a = ia_q;
	assign rd_addr_b = ib_q;
	assign row       = i_q;
	assign col       = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= A_ROWS_RESET;
			inner_len_q <= INNER_LEN_RESET;
			b_cols_q    <= B_COLS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_A_ROWS:    a_rows_q    <= cfg_data;
				REG_INNER_LEN: inner_len_q <= cfg_data;
				REG_B_COLS:    b_cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			a_fill_q <= '0;
			b_fill_q <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			a_base_q <= '0;
			ia_q     <= '0;
			ib_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.wr_a)
				a_fill_q <= a_fill_q + FW'(1);
			if (cmd.wr_b)
				b_fill_q <= b_fill_q + FW'(1);
			if (accept && s_kind == KIND_START) begin
				// rewind the write pointers and the loop
				a_fill_q <= '0;
				b_fill_q <= '0;
				i_q      <= '0;
				j_q      <= '0;
				k_q      <= '0;
				a_base_q <= '0;
				ia_q     <= '0;
				ib_q     <= '0;
			end
			if (cmd.issue) begin
				if (!k_end) begin
					k_q  <= k_q + IW'(1);
					ia_q <= ia_q + AW'(1);
					ib_q <= ib_q + AW'(cols_eff);
				end else begin
					k_q <= '0;
					if (j_q == IW'(cols_eff - DW'(1))) begin
						j_q      <= '0;
						i_q      <= i_q + IW'(1);
						a_base_q <= a_base_q + AW'(inner_eff);
						ia_q     <= a_base_q + AW'(inner_eff);
						ib_q     <= '0;
					end else begin
						j_q  <= j_q + IW'(1);
						ia_q <= a_base_q;
						ib_q <= AW'(j_q) + AW'(1);
					end
				end
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (s_kind)
						KIND_LOAD_A: cmd.wr_a = (a_fill_q < FW'(CAP));
						KIND_LOAD_B: cmd.wr_b = (b_fill_q < FW'(CAP));
						KIND_START:  state_d  = ST_WAIT;
						default: ;
					endcase
				end
			end
			ST_WAIT: begin
				if (!stat.pipe_busy && !stat.out_full)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.issue     = 1'b1;
				cmd.first_k   = (k_q == '0);
				cmd.last_k    = k_end;
				cmd.last_elem = elem_end;
				if (k_end)
					state_d = elem_end ? ST_IDLE : ST_WAIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_a |-> a_fill_q < FW'(CAP))
		else $error("store A written past capacity");

	b_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_b |-> b_fill_q < FW'(CAP))
		else $error("store B written past capacity");

	issue_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.first_k) |-> (!stat.out_full && !stat.pipe_busy))
		else $error("element started while a result is pending");

endmodule

// ===== design/mme_datapath.sv =====
module mme_datapath #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mme_pkg::mme_cmd_t                    cmd,
	output mme_pkg::mme_stat_t                   stat,
	input  logic [mme_pkg::VALUE_WIDTH-1:0]      wr_value,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr_a,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr_b,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr_a,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr_b,
	input  logic [$clog2(MAX_DIM)-1:0]           row_in,
	input  logic [$clog2(MAX_DIM)-1:0]           col_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mme_pkg::PROD_WIDTH-1:0]       product,
	output logic [mme_pkg::IDX_WIDTH-1:0]        row,
	output logic [mme_pkg::IDX_WIDTH-1:0]        col,
	output logic                                 last
);
	import mme_pkg::*;

	localparam int CAP = MAX_DIM * MAX_DIM;
	localparam int IW  = $clog2(MAX_DIM);
	localparam int EW  = ELEM_WIDTH;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] OUT_MAX = ACC_WIDTH'(64'sd2147483647);
	localparam logic signed [ACC_WIDTH-1:0] OUT_MIN = -ACC_WIDTH'(64'sd2147483648);

	logic [EW-1:0] mem_a [CAP];
	logic [EW-1:0] mem_b [CAP];
	logic [EW-1:0] wr_elem;

	logic                   v_s1, first_s1, last_k_s1, last_e_s1;
	logic [IW-1:0]          row_s1, col_s1;
	logic [EW-1:0]          a_s1, b_s1;
	logic                   v_s2, first_s2, last_k_s2, last_e_s2;
	logic [IW-1:0]          row_s2, col_s2;
	logic signed [2*EW-1:0] prod_s2;
	logic                   done_s3, last_e_s3;
	logic [IW-1:0]          row_s3, col_s3;
	logic signed [ACC_WIDTH-1:0] acc_q, prod_ext, sum, acc_d;
	logic                   ovf;
	logic                   out_valid_q, last_q;
	logic [PROD_WIDTH-1:0]  product_q;
	logic [IDX_WIDTH-1:0]   row_q, col_q;

	// elements narrower than the port keep the low bits, wider ones zero-extend
	assign wr_elem = EW'(wr_value);

	always_ff @(posedge clk) begin
		if (cmd.wr_a)
			mem_a[wr_addr_a] <= wr_elem;
		a_s1 <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b)
			mem_b[wr_addr_b] <= wr_elem;
		b_s1 <= mem_b[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && last_k_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= cmd.first_k;
		last_k_s1 <= cmd.last_k;
		last_e_s1 <= cmd.last_elem;
		row_s1    <= row_in;
		col_s1    <= col_in;

		first_s2  <= first_s1;
		last_k_s2 <= last_k_s1;
		last_e_s2 <= last_e_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		prod_s2   <= $signed(a_s1) * $signed(b_s1);

		if (v_s2) begin
			acc_q     <= acc_d;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			last_e_s3 <= last_e_s2;
		end
	end

	// saturating accumulate
	always_comb begin
		prod_ext = ACC_WIDTH'(prod_s2);
		sum      = acc_q + prod_ext;
		ovf      = (acc_q[ACC_WIDTH-1] == prod_ext[ACC_WIDTH-1]) &&
		           (sum[ACC_WIDTH-1] != acc_q[ACC_WIDTH-1]);
		if (first_s2)
			acc_d = prod_ext;
		else if (ovf)
			acc_d = acc_q[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
		else
			acc_d = sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_s3)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			if (acc_q > OUT_MAX)
				product_q <= PROD_WIDTH'(OUT_MAX);
			else if (acc_q < OUT_MIN)
				product_q <= PROD_WIDTH'(OUT_MIN);
			else
				product_q <= acc_q[PROD_WIDTH-1:0];
			row_q  <= IDX_WIDTH'(row_s3);
			col_q  <= IDX_WIDTH'(col_s3);
			last_q <= last_e_s3;
		end
	end

	assign stat.pipe_busy = v_s1 || v_s2 || done_s3;
	assign stat.out_full  = out_valid_q;
	assign out_valid      = out_valid_q;
	assign product        = product_q;
	assign row            = row_q;
	assign col            = col_q;
	assign last           = last_q;

	no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		done_s3 |-> !out_valid_q)
		else $error("result register overwritten");

	one_element_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_k_s2) |-> !(v_s1 && !first_s1))
		else $error("two elements interleaved in the pipeline");

	result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(product_q)))
		else $error("result item changed while waiting");

endmodule

// ===== design/matrix_multiply_engine_top.sv =====
// Dense matrix multiply C = A x B on signed Q8.8 elements, giving signed
// Q16.16 results saturated to 32 bits. Input items of kind 0 append the next
// element of A and kind 1 the next element of B, both in row-major order;
// loads past MAX_DIM*MAX_DIM elements are dropped. A kind 2 item starts the
// multiply, rewinds both load pointers and then emits a_rows*b_cols result
// items in row-major order with their row and column, tlast marking the last.
// Kind 3 is accepted and ignored. Dimension registers read as 1 when zero and
// as MAX_DIM when larger. Every element used by a multiply must have been
// loaded first; unloaded entries read as arbitrary values.
// Timing: each result takes one read of A and B per inner step from the element
// memories, then the multiply, accumulate and saturate stages drain before the
// next element is started, and that element waits until the previous result has
// been taken. Loads are taken again as soon as the last element's reads are
// issued, while its result is still in flight. Configuration writes are
// never held off.
module matrix_multiply_engine_top #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] product, [34:32] row, [37:35] col, [39:38] zero
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import mme_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int IW = $clog2(MAX_DIM);

	mme_cmd_t              cmd;
	mme_stat_t             stat;
	logic [AW-1:0]         wr_addr_a, wr_addr_b, rd_addr_a, rd_addr_b;
	logic [IW-1:0]         row_idx, col_idx;
	logic [PROD_WIDTH-1:0] product;
	logic [IDX_WIDTH-1:0]  row, col;

	// sequencing, load pointers and dimension registers
	mme_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_kind    (s_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.wr_addr_a (wr_addr_a),
		.wr_addr_b (wr_addr_b),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.row       (row_idx),
		.col       (col_idx)
	);

	// element memories, multiply-accumulate pipeline and result register
	mme_datapath #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.wr_value  (s_tdata),
		.wr_addr_a (wr_addr_a),
		.wr_addr_b (wr_addr_b),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.row_in    (row_idx),
		.col_in    (col_idx),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.product   (product),
		.row       (row),
		.col       (col),
		.last      (m_tlast)
	);

	// pack the result item, padding to whole bytes
	assign m_tdata = {2'b00, col, row, product};

endmodule

// ===== tb/sv/matrix_product_checker.sv =====
module matrix_product_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	input  logic [1:0]  s_tuser,   // [1:0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [31:0] product, [34:32] row, [37:35] col, [39:38] zero
	input  logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output int          fail_count,
	output int          outstanding,
	output int          checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	localparam int DIM_LIMIT   = 8;
	localparam int STORE_DEPTH = DIM_LIMIT * DIM_LIMIT;
	localparam longint PROD_MAX = (longint'(1) <<< (PROD_WIDTH - 1)) - 1;
	localparam longint PROD_MIN = -(longint'(1) <<< (PROD_WIDTH - 1));

	typedef struct packed {
		logic [PROD_WIDTH-1:0] product;
		logic [IDX_WIDTH-1:0]  row;
		logic [IDX_WIDTH-1:0]  col;
		logic                  last;
	} c_elem_t;

	logic [CFG_WIDTH-1:0]          rows_reg, inner_reg, cols_reg;
	logic signed [VALUE_WIDTH-1:0] elems_a [STORE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] elems_b [STORE_DEPTH];
	int                            fill_a, fill_b;
	int                            errs, seen;
	c_elem_t                       pending_products [$];

	// zero reads as one, anything above the array size as the array size
	function automatic int clamp_dim(input logic [CFG_WIDTH-1:0] raw);
		if (raw == '0)
			return 1;
		if (raw > DIM_LIMIT)
			return DIM_LIMIT;
		return int'(raw);
	endfunction

	// Queue every element of C in row-major order, exact sum then one saturation
	task automatic predict_products();
		int      n_rows, n_inner, n_cols, i, j, k;
		longint  acc;
		c_elem_t elem;
		n_rows  = clamp_dim(rows_reg);
		n_inner = clamp_dim(inner_reg);
		n_cols  = clamp_dim(cols_reg);
		for (i = 0; i < n_rows; i++) begin
			for (j = 0; j < n_cols; j++) begin
				acc = 0;
				for (k = 0; k < n_inner; k++)
					acc += longint'(elems_a[(i * n_inner + k) % STORE_DEPTH]) *
						longint'(elems_b[(k * n_cols + j) % STORE_DEPTH]);
				if (acc > PROD_MAX)
					acc = PROD_MAX;
				if (acc < PROD_MIN)
					acc = PROD_MIN;
				elem.product = acc[PROD_WIDTH-1:0];
				elem.row     = IDX_WIDTH'(i);
				elem.col     = IDX_WIDTH'(j);
				elem.last    = (i == n_rows - 1) && (j == n_cols - 1);
				pending_products.push_back(elem);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		c_elem_t want;
		c_elem_t got;
		if (!arst_n) begin
			rows_reg  = A_ROWS_RESET;
			inner_reg = INNER_LEN_RESET;
			cols_reg  = B_COLS_RESET;
			fill_a    = 0;
			fill_b    = 0;
			errs      = 0;
			seen      = 0;
			pending_products.delete();
			fail_count    <= 0;
			outstanding   <= 0;
			checked_count <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_A_ROWS:    rows_reg  = cfg_data;
					REG_INNER_LEN: inner_reg = cfg_data;
					REG_B_COLS:    cols_reg  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					KIND_LOAD_A: if (fill_a < STORE_DEPTH) begin
						elems_a[fill_a] = s_tdata;
						fill_a++;
					end
					KIND_LOAD_B: if (fill_b < STORE_DEPTH) begin
						elems_b[fill_b] = s_tdata;
						fill_b++;
					end
					KIND_START: begin
						predict_products();
						fill_a = 0;
						fill_b = 0;
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.product = m_tdata[31:0];
				got.row     = m_tdata[34:32];
				got.col     = m_tdata[37:35];
				got.last    = m_tlast;
				seen++;
				if (pending_products.size() == 0) begin
					$display("%0t: unexpected result item row %0d col %0d product %h",
						$time, got.row, got.col, got.product);
					errs++;
				end else begin
					want = pending_products.pop_front();
					if (got.product !== want.product) begin
						$display("%0t: product mismatch: expected %h, actual %h",
							$time, want.product, got.product);
						errs++;
					end
					if (got.row !== want.row) begin
						$display("%0t: row mismatch: expected %0d, actual %0d",
							$time, want.row, got.row);
						errs++;
					end
					if (got.col !== want.col) begin
						$display("%0t: col mismatch: expected %0d, actual %0d",
							$time, want.col, got.col);
						errs++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last flag mismatch: expected %b, actual %b",
							$time, want.last, got.last);
						errs++;
					end
				end
			end
			fail_count    <= errs;
			outstanding   <= pending_products.size();
			checked_count <= seen;
		end
	end

endmodule

// ===== tb/sv/matrix_multiply_engine_top_test.sv =====
module matrix_multiply_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	// Kind 3 has no meaning to the block; it is accepted and dropped
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int STORE_DEPTH  = 64;
	localparam int RANDOM_ITEMS = 200;
	localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
	localparam int SETTLE       = 20;    // lets the last element's pipeline settle, with margin

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] value
	logic [1:0]  s_tuser;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] product, [34:32] row, [37:35] col, [39:38] zero
	logic        m_tlast;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;

	int fail_count;
	int outstanding;
	int checked_count;

	// Handshake between stimulus and the receiver: bump to ask for a long hold-off
	int hold_ask = 0;

	// Sender pacing and bookkeeping
	int burst_left = 0;
	int sent       = 0;
	int starts     = 0;
	int settings   = 0;

	// Load pointers as the block sees them, and how far each store has ever been
	// written; a start is only issued when every entry it reads lies below that mark
	int fill_a  = 0;
	int fill_b  = 0;
	int valid_a = 0;
	int valid_b = 0;

	logic [CFG_WIDTH-1:0] raw_rows  = A_ROWS_RESET;
	logic [CFG_WIDTH-1:0] raw_inner = INNER_LEN_RESET;
	logic [CFG_WIDTH-1:0] raw_cols  = B_COLS_RESET;

	matrix_multiply_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	matrix_product_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Effective dimension as the block uses it, for sizing the load sequences
	function automatic int dim_of(input logic [CFG_WIDTH-1:0] raw);
		if (raw == '0)
			return 1;
		return (raw > 4'd8) ? 8 : int'(raw);
	endfunction

	// Mostly small sizes so that the run stays short; now and then zero, the
	// largest legal size, or a value above range
	function automatic logic [CFG_WIDTH-1:0] rand_dim();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_WIDTH'($urandom_range(9, 15));
			2:       return CFG_WIDTH'(8);
			default: return CFG_WIDTH'($urandom_range(1, 4));
		endcase
	endfunction

	// Element values: a fair share of the Q8.8 extremes to push the sums into
	// saturation, the rest fully random
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one item and hold it until the block takes it. Bursts of random
	// length, separated by random gaps; some bursts follow on with no gap at all.
	task automatic send_item(input logic [1:0] kind, input logic [15:0] value);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		case (kind)
			KIND_LOAD_A: if (fill_a < STORE_DEPTH) fill_a++;
			KIND_LOAD_B: if (fill_b < STORE_DEPTH) fill_b++;
			KIND_START: begin
				fill_a = 0;
				fill_b = 0;
				starts++;
			end
			default: ;
		endcase
		if (fill_a > valid_a)
			valid_a = fill_a;
		if (fill_b > valid_b)
			valid_b = fill_b;
		if (kind != KIND_UNUSED)
			sent++;
	endtask

	// Stop offering and wait until every predicted result has been taken, then
	// let the last element's pipeline settle. The first edge lets the checker's
	// count catch up with an item taken on the edge just gone.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all three dimension registers back to back; only call when idle
	task automatic write_dims(input logic [CFG_WIDTH-1:0] rows,
			input logic [CFG_WIDTH-1:0] inner, input logic [CFG_WIDTH-1:0] cols);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_A_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= REG_INNER_LEN;
		cfg_data  <= inner;
		@(posedge clk);
		cfg_index <= REG_B_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		raw_rows  = rows;
		raw_inner = inner;
		raw_cols  = cols;
		settings++;
	endtask

	// One multiply: A and B loads interleaved at random, then a start. Now and
	// then load short (only where earlier loads already cover every entry read),
	// overfill past what is needed, or slip in an ignored kind.
	task automatic run_multiply(input bit long_hold, input int overfill);
		int need_a, need_b, goal_a, goal_b, na, nb;
		need_a = dim_of(raw_rows) * dim_of(raw_inner);
		need_b = dim_of(raw_inner) * dim_of(raw_cols);
		goal_a = need_a + overfill;
		goal_b = need_b + overfill;
		if (valid_a >= need_a && $urandom_range(0, 4) == 0)
			goal_a = $urandom_range(0, need_a);
		if (valid_b >= need_b && $urandom_range(0, 4) == 0)
			goal_b = $urandom_range(0, need_b);
		if ($urandom_range(0, 5) == 0)
			goal_a += $urandom_range(1, 4);
		if ($urandom_range(0, 5) == 0)
			goal_b += $urandom_range(1, 4);
		na = 0;
		nb = 0;
		while (na < goal_a || nb < goal_b) begin
			if ($urandom_range(0, 19) == 0)
				send_item(KIND_UNUSED, 16'($urandom));
			if (nb >= goal_b || (na < goal_a && $urandom_range(0, 1) == 0)) begin
				send_item(KIND_LOAD_A, pick_value());
				na++;
			end else begin
				send_item(KIND_LOAD_B, pick_value());
				nb++;
			end
		end
		// the receiver starts its hold-off before any result
		if (long_hold)
			hold_ask++;
		send_item(KIND_START, 16'($urandom));
	endtask

	// Result receiver: stretches of steady readiness, light stalls and heavy
	// stalls, plus a long hold-off whenever the stimulus asks for one
	initial begin : result_sink
		int seen_hold, stretch, mode;
		seen_hold = 0;
		stretch   = 0;
		mode      = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != seen_hold) begin
				seen_hold = hold_ask;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(4, 40);
					mode    = $urandom_range(0, 2);
				end
				stretch--;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 1) == 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int directed_sent;
		int phase;
		arst_n = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= KIND_LOAD_A;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_A_ROWS;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions, 4 x 2 by 2 x 1. Row 0 stays just inside the negative
		// range, row 1 saturates high, row 2 nearly cancels and row 3 cancels
		// exactly. An ignored kind sits among the loads.
		send_item(KIND_LOAD_A, 16'h7FFF);
		send_item(KIND_LOAD_A, 16'h7FFF);
		send_item(KIND_LOAD_A, 16'h8000);
		send_item(KIND_LOAD_A, 16'h8000);
		send_item(KIND_UNUSED, 16'hFFFF);
		send_item(KIND_LOAD_A, 16'h8000);
		send_item(KIND_LOAD_A, 16'h7FFF);
		send_item(KIND_LOAD_B, 16'h8000);
		send_item(KIND_LOAD_A, 16'h0001);
		send_item(KIND_LOAD_A, 16'hFFFF);
		send_item(KIND_LOAD_B, 16'h8000);
		send_item(KIND_START, 16'hFFFF);
		drain();

		// Zero rows and columns read as one; three large negative terms
		// saturate low
		write_dims(4'd0, 4'd3, 4'd0);
		send_item(KIND_LOAD_A, 16'h8000);
		send_item(KIND_LOAD_B, 16'h7FFF);
		send_item(KIND_LOAD_A, 16'h8000);
		send_item(KIND_LOAD_B, 16'h7FFF);
		send_item(KIND_LOAD_A, 16'h8000);
		send_item(KIND_LOAD_B, 16'h7FFF);
		send_item(KIND_START, 16'h0000);
		// start again with nothing loaded: the stores keep their contents
		send_item(KIND_START, 16'h5A5A);
		directed_sent = sent;

		phase = 0;
		while (sent - directed_sent < RANDOM_ITEMS) begin
			drain();
			if (phase == 0) begin
				// Every register above range gives the full 8 x 8 by 8 x 8 product.
				// Overfill both stores, hold the receiver off and keep offering
				// items so that the block backs up into its input.
				write_dims(4'd15, 4'd15, 4'd15);
				run_multiply(1'b1, 3);
				repeat (6)
					send_item(($urandom_range(0, 1) == 0) ? KIND_LOAD_A : KIND_LOAD_B,
						pick_value());
				send_item(KIND_START, 16'($urandom));
			end else begin
				write_dims(rand_dim(), rand_dim(), rand_dim());
				repeat ($urandom_range(1, 4)) begin
					if (sent - directed_sent < RANDOM_ITEMS) begin
						run_multiply(1'b0, 0);
						// sometimes pause until every result is back
						if ($urandom_range(0, 3) == 0)
							drain();
					end
				end
			end
			phase++;
		end

		drain();
		$display("covered %0d load and start items, %0d multiplies, %0d dimension settings",
			sent, starts, settings);
		$display("compared %0d result items, %0d mismatches", checked_count, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Backstop against a hung handshake
	initial begin : watchdog
		#50ms;
		$display("timeout with %0d results still outstanding", outstanding);
		$display("status: fail");
		$finish;
	end

endmodule
